FILE: design/pse_pkg.sv
// shared types and constants for the postfix stack evaluator
// no dependencies
package pse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int TOK_W       = 8;
	localparam int ANSWER_W    = 32;
	localparam int LEFT_W      = 5;
	localparam int STATUS_W    = 2;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

	localparam logic [TOK_W-1:0] CH_ADD = 8'h2B;
	localparam logic [TOK_W-1:0] CH_SUB = 8'h2D;
	localparam logic [TOK_W-1:0] CH_MUL = 8'h2A;
	localparam logic [TOK_W-1:0] CH_DIV = 8'h2F;
	localparam logic [TOK_W-1:0] CH_XOR = 8'h5E;
	localparam logic [TOK_W-1:0] CH_REM = 8'h25;
	localparam logic [TOK_W-1:0] CH_AND = 8'h26;
	localparam logic [TOK_W-1:0] CH_0   = 8'h30;
	localparam logic [TOK_W-1:0] CH_9   = 8'h39;

	typedef enum logic [2:0] {
		OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_XOR, OP_AND
	} op_t;

	// decoded command passed from front to back; other characters set the pass flag
	typedef struct packed {
		op_t        op;
		logic       pass;
		logic [3:0] digit;
		logic       last;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

endpackage

FILE: design/postfix_stack_evaluator.sv
// top level of the postfix stack evaluator
// depends on pse_pkg, pse_front, pse_back
//
// channel   direction  handshake       fields
// token     in         push / full     token_char, last_token
// result    out        pop / empty     answer, stack_left, status
//
// a digit goes from S_IDLE to S_WRITE; an operator passes S_RD2, S_RD1, S_CAP1, S_EXEC
// multiply adds S_MUL; divide and remainder wait in S_DIV for the serial divider
// a last token adds S_LRD and S_LWAIT to read the top of stack and load the result register
// a two-entry command queue lets tokens be taken while the back end works
// reset clears counts and status; stack contents are undefined until pushed
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH,
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [pse_pkg::TOK_W-1:0]     token_char,
	input  logic                          last_token,
	output logic                          empty,
	input  logic                          pop,
	output logic [pse_pkg::ANSWER_W-1:0]  answer,
	output logic [pse_pkg::LEFT_W-1:0]    stack_left,
	output logic [pse_pkg::STATUS_W-1:0]  status
);
	logic          cmd_valid, cmd_take;
	pse_pkg::cmd_t cmd;

	pse_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.token_char(token_char), .last_token(last_token),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	pse_back #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .answer(answer),
		.stack_left(stack_left), .status(status)
	);

	// back end only takes a command that the queue holds
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("command taken from empty queue");

	// result never reports more values than the stack holds
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> stack_left <= pse_pkg::LEFT_W'(STACK_DEPTH))
		else $error("stack_left out of range");

	// an empty stack at the end cannot report ok
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && stack_left == '0) |-> status != pse_pkg::ST_OK)
		else $error("empty stack reported ok");
endmodule

FILE: design/pse_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: design/pse_front.sv
// front end: token decode into a small command queue
// depends on pse_pkg
module pse_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [pse_pkg::TOK_W-1:0] token_char,
	input  logic                    last_token,
	output logic                    cmd_valid,
	output pse_pkg::cmd_t           cmd,
	input  logic                    cmd_take
);
	localparam int AW = $clog2(pse_pkg::FIFO_DEPTH);

	pse_pkg::cmd_t     buf_q [pse_pkg::FIFO_DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;
	pse_pkg::cmd_t     dec;
	logic              wr, rd;

	always_comb begin
		dec.last  = last_token;
		dec.digit = token_char[3:0];
		dec.pass  = 1'b0;
		dec.op    = pse_pkg::OP_PUSH;
		if (token_char >= pse_pkg::CH_0 && token_char <= pse_pkg::CH_9) begin
			dec.digit = 4'(token_char - pse_pkg::CH_0);
		end else begin
			unique case (token_char)
				pse_pkg::CH_ADD: dec.op = pse_pkg::OP_ADD;
				pse_pkg::CH_SUB: dec.op = pse_pkg::OP_SUB;
				pse_pkg::CH_MUL: dec.op = pse_pkg::OP_MUL;
				pse_pkg::CH_DIV: dec.op = pse_pkg::OP_DIV;
				pse_pkg::CH_REM: dec.op = pse_pkg::OP_REM;
				pse_pkg::CH_XOR: dec.op = pse_pkg::OP_XOR;
				pse_pkg::CH_AND: dec.op = pse_pkg::OP_AND;
				default: begin
					dec.op   = pse_pkg::OP_ADD;
					dec.pass = 1'b1;
				end
			endcase
		end
	end

	assign full      = (cnt_q == (AW+1)'(pse_pkg::FIFO_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = buf_q[rp_q];
	assign wr        = push && !full;
	assign rd        = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) buf_q[wp_q] <= dec;
	end
endmodule

FILE: design/pse_div.sv
// serial signed divider, one quotient bit per cycle
// depends on nothing beyond its parameter
module pse_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q, d_q;
	logic [W:0]    r_q;
	logic [CW-1:0] n_q;
	logic          busy_q, nq_q, nr_q;
	logic [W:0]    sh, df;

	assign sh = {r_q[W-1:0], q_q[W-1]};
	assign df = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			n_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= CW'(W);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend[W-1] ? -dividend : dividend;
			d_q  <= divisor[W-1] ? -divisor : divisor;
			r_q  <= '0;
			nq_q <= dividend[W-1] ^ divisor[W-1];
			nr_q <= dividend[W-1];
		end else if (busy_q) begin
			if (!df[W]) begin
				r_q <= df;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quot = nq_q ? -q_q : q_q;
	assign rem  = nr_q ? -r_q[W-1:0] : r_q[W-1:0];
endmodule

FILE: design/pse_back.sv
// back end: stack sequencer, alu, divider and result register
// depends on pse_pkg, pse_ram, pse_div
module pse_back #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH,
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  pse_pkg::cmd_t                 cmd,
	output logic                          cmd_take,
	output logic                          empty,
	input  logic                          pop,
	output logic [pse_pkg::ANSWER_W-1:0]  answer,
	output logic [pse_pkg::LEFT_W-1:0]    stack_left,
	output logic [pse_pkg::STATUS_W-1:0]  status
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int W  = VALUE_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE, S_RD2, S_RD1, S_CAP1, S_EXEC, S_MUL, S_DIV, S_WRITE, S_LRD, S_LWAIT, S_OUT
	} state_t;

	state_t                     state_q;
	pse_pkg::cmd_t              cmd_q;
	logic [CW-1:0]              cnt_q;
	logic [pse_pkg::STATUS_W-1:0] err_q;
	logic [W-1:0]               a_q, b_q, res_q;
	logic                       av_q, bv_q;
	logic                       ram_we;
	logic [AW-1:0]              ram_wa, ram_ra;
	logic [W-1:0]               ram_rd;
	logic                       dstart, ddone;
	logic [W-1:0]               quot, remd;
	logic                       out_full_q;

	assign ram_we = (state_q == S_WRITE) && (cnt_q < CW'(STACK_DEPTH));
	assign ram_wa = cnt_q[AW-1:0];
	assign ram_ra = AW'(cnt_q - 1'b1);

	pse_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(res_q),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	assign dstart = (state_q == S_EXEC) && (b_q != '0) &&
		(cmd_q.op == pse_pkg::OP_DIV || cmd_q.op == pse_pkg::OP_REM) && !cmd_q.pass;

	pse_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(a_q), .divisor(b_q),
		.done(ddone), .quot(quot), .rem(remd)
	);

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign empty    = !out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			err_q      <= pse_pkg::ST_OK;
			out_full_q <= 1'b0;
		end else begin
			// the result slot is refilled in S_LWAIT, which handles a pop there itself
			if (pop && out_full_q && state_q != S_LWAIT) out_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					cmd_q <= cmd;
					if (cmd.op == pse_pkg::OP_PUSH) begin
						res_q   <= W'(cmd.digit);
						state_q <= S_WRITE;
					end else begin
						state_q <= S_RD2;
					end
				end
				// pop top operand
				S_RD2: begin
					bv_q <= (cnt_q != '0);
					if (cnt_q == '0) begin
						if (err_q == pse_pkg::ST_OK) err_q <= pse_pkg::ST_UNDER;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= S_RD1;
				end
				S_RD1: begin
					b_q  <= bv_q ? ram_rd : '0;
					av_q <= (cnt_q != '0);
					if (cnt_q == '0) begin
						if (err_q == pse_pkg::ST_OK) err_q <= pse_pkg::ST_UNDER;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= S_CAP1;
				end
				S_CAP1: begin
					a_q     <= av_q ? ram_rd : '0;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_WRITE;
					if (cmd_q.pass) begin
						res_q <= a_q;
					end else begin
						unique case (cmd_q.op)
							pse_pkg::OP_ADD: res_q <= a_q + b_q;
							pse_pkg::OP_SUB: res_q <= a_q - b_q;
							pse_pkg::OP_XOR: res_q <= a_q ^ b_q;
							pse_pkg::OP_AND: res_q <= a_q & b_q;
							pse_pkg::OP_MUL: state_q <= S_MUL;
							pse_pkg::OP_DIV, pse_pkg::OP_REM: begin
								if (b_q == '0) begin
									res_q <= '0;
									if (err_q == pse_pkg::ST_OK) err_q <= pse_pkg::ST_DIVZ;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: res_q <= a_q;
						endcase
					end
				end
				S_MUL: begin
					res_q   <= W'(a_q * b_q);
					state_q <= S_WRITE;
				end
				S_DIV: if (ddone) begin
					res_q   <= (cmd_q.op == pse_pkg::OP_DIV) ? quot : remd;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (cnt_q < CW'(STACK_DEPTH)) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (err_q == pse_pkg::ST_OK) begin
						err_q <= pse_pkg::ST_OVER;
					end
					state_q <= cmd_q.last ? S_LRD : S_IDLE;
				end
				S_LRD: state_q <= S_LWAIT;
				// wait for result slot, then emit and clear
				S_LWAIT: if (!out_full_q || pop) begin
					answer     <= (cnt_q == '0) ? '0 : pse_pkg::ANSWER_W'(ram_rd);
					stack_left <= pse_pkg::LEFT_W'(cnt_q);
					status     <= (cnt_q == '0 && err_q == pse_pkg::ST_OK) ?
						pse_pkg::ST_UNDER : err_q;
					out_full_q <= 1'b1;
					cnt_q      <= '0;
					err_q      <= pse_pkg::ST_OK;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: tb/pse_checker.sv
// checker for the postfix stack evaluator: watches both channels, predicts results
// depends on pse_pkg; hands its mismatch count to the testbench top
module pse_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic [pse_pkg::TOK_W-1:0]     token_char,
	input  logic                          last_token,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [pse_pkg::ANSWER_W-1:0]  answer,
	input  logic [pse_pkg::LEFT_W-1:0]    stack_left,
	input  logic [pse_pkg::STATUS_W-1:0]  status,
	output int                            errors,
	output int                            pending
);
	typedef struct packed {
		logic [pse_pkg::ANSWER_W-1:0] answer;
		logic [pse_pkg::LEFT_W-1:0]   left;
		logic [pse_pkg::STATUS_W-1:0] status;
	} outcome_t;

	logic [pse_pkg::VALUE_WIDTH-1:0] vals [pse_pkg::STACK_DEPTH];
	int                              depth;
	logic [pse_pkg::STATUS_W-1:0]    sticky;
	outcome_t                        outcomes [$];

	function automatic void note(logic [pse_pkg::STATUS_W-1:0] code);
		if (sticky == pse_pkg::ST_OK)
			sticky = code;
	endfunction

	function automatic void put(logic [pse_pkg::VALUE_WIDTH-1:0] v);
		if (depth >= pse_pkg::STACK_DEPTH) begin
			note(pse_pkg::ST_OVER);
			return;
		end
		vals[depth] = v;
		depth++;
	endfunction

	function automatic logic [pse_pkg::VALUE_WIDTH-1:0] take();
		if (depth == 0) begin
			note(pse_pkg::ST_UNDER);
			return '0;
		end
		depth--;
		return vals[depth];
	endfunction

	function automatic logic [pse_pkg::VALUE_WIDTH-1:0] combine(
			logic [pse_pkg::TOK_W-1:0] t,
			logic [pse_pkg::VALUE_WIDTH-1:0] a, logic [pse_pkg::VALUE_WIDTH-1:0] b);
		logic [pse_pkg::VALUE_WIDTH-1:0] ma, mb, q;
		ma = a[pse_pkg::VALUE_WIDTH-1] ? -a : a;
		mb = b[pse_pkg::VALUE_WIDTH-1] ? -b : b;
		case (t)
			pse_pkg::CH_ADD: return a + b;
			pse_pkg::CH_SUB: return a - b;
			pse_pkg::CH_MUL: return a * b;
			pse_pkg::CH_XOR: return a ^ b;
			pse_pkg::CH_AND: return a & b;
			pse_pkg::CH_DIV: begin
				if (b == 0) begin
					note(pse_pkg::ST_DIVZ);
					return '0;
				end
				q = ma / mb;
				return (a[pse_pkg::VALUE_WIDTH-1] != b[pse_pkg::VALUE_WIDTH-1]) ? -q : q;
			end
			pse_pkg::CH_REM: begin
				if (b == 0) begin
					note(pse_pkg::ST_DIVZ);
					return '0;
				end
				q = ma % mb;
				return a[pse_pkg::VALUE_WIDTH-1] ? -q : q;
			end
			default: return a;
		endcase
	endfunction

	task automatic evaluate(logic [pse_pkg::TOK_W-1:0] t, logic fin);
		logic [pse_pkg::VALUE_WIDTH-1:0] rhs, lhs;
		outcome_t o;
		if (t >= pse_pkg::CH_0 && t <= pse_pkg::CH_9)
			put(pse_pkg::VALUE_WIDTH'(t - pse_pkg::CH_0));
		else begin
			rhs = take();
			lhs = take();
			put(combine(t, lhs, rhs));
		end
		if (fin) begin
			if (depth == 0) begin
				note(pse_pkg::ST_UNDER);
				o.answer = '0;
			end else
				o.answer = vals[depth-1][pse_pkg::ANSWER_W-1:0];
			o.left = pse_pkg::LEFT_W'(depth);
			o.status = sticky;
			outcomes.push_back(o);
			depth = 0;
			sticky = pse_pkg::ST_OK;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			depth = 0;
			sticky = pse_pkg::ST_OK;
			errors = 0;
			outcomes.delete();
			pending = 0;
		end else begin
			if (push && !full)
				evaluate(token_char, last_token);
			if (pop && !empty) begin
				if (outcomes.size() == 0) begin
					$display("%0t: unexpected result answer=%h left=%0d status=%0d",
						$time, answer, stack_left, status);
					errors++;
				end else begin
					want = outcomes.pop_front();
					if (answer !== want.answer) begin
						$display("%0t: answer expected %h actual %h", $time,
							want.answer, answer);
						errors++;
					end
					if (stack_left !== want.left) begin
						$display("%0t: stack_left expected %0d actual %0d", $time,
							want.left, stack_left);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, status);
						errors++;
					end
				end
			end
			pending = outcomes.size();
		end
	end
endmodule

FILE: tb/postfix_stack_evaluator_tb.sv
// stimulus and verdict for the postfix stack evaluator
// depends on pse_pkg, postfix_stack_evaluator and pse_checker
module postfix_stack_evaluator_tb;
	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic [pse_pkg::TOK_W-1:0]    token_char;
	logic                         last_token;
	logic                         empty;
	logic                         pop;
	logic [pse_pkg::ANSWER_W-1:0] answer;
	logic [pse_pkg::LEFT_W-1:0]   stack_left;
	logic [pse_pkg::STATUS_W-1:0] status;
	int                           errors;
	int                           pending;
	bit                           calm;
	bit                           hold_off;

	localparam logic [pse_pkg::TOK_W-1:0] OPS [7] = '{pse_pkg::CH_ADD, pse_pkg::CH_SUB,
		pse_pkg::CH_MUL, pse_pkg::CH_DIV, pse_pkg::CH_XOR, pse_pkg::CH_REM, pse_pkg::CH_AND};

	postfix_stack_evaluator uut (.*);

	pse_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random pops, long hold-off on request
	initial begin
		pop = 0;
		forever begin
			@(negedge clk);
			if (hold_off)
				pop <= 0;
			else
				pop <= calm || ($urandom_range(99) >= 21);
		end
	end

	// push stays high after a transaction so that the next one can follow at once
	task automatic send(logic [pse_pkg::TOK_W-1:0] t, logic fin);
		do begin
			@(negedge clk);
			if (!calm && $urandom_range(99) < 21) begin
				push <= 0;
				@(negedge clk);
			end
			push <= 1;
			token_char <= t;
			last_token <= fin;
			@(posedge clk);
		end while (full);
	endtask

	function automatic logic [pse_pkg::TOK_W-1:0] digit();
		return pse_pkg::CH_0 + pse_pkg::TOK_W'($urandom_range(9));
	endfunction

	function automatic logic [pse_pkg::TOK_W-1:0] any_op();
		return OPS[$urandom_range(6)];
	endfunction

	// a well-formed expression of n operands, last flag on the final token
	task automatic expression(int n);
		int held;
		held = 0;
		for (int i = 0; i < 2 * n - 1; i++) begin
			if (held < 2 || (i < 2 * n - 1 && held + (2 * n - 1 - i) > 2 * n - i - 1 + 0
					&& $urandom_range(1) && (i - held) / 2 + held < n))
				begin
				send(digit(), i == 2 * n - 2);
				held++;
			end else begin
				send(any_op(), i == 2 * n - 2);
				held--;
			end
		end
	endtask

	initial begin
		int count;
		push = 0;
		token_char = '0;
		last_token = 0;
		calm = 0;
		hold_off = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: every operator, extremes and the error cases
		send(pse_pkg::CH_0, 1);
		send(pse_pkg::CH_9, 1);
		foreach (OPS[k]) begin
			send(pse_pkg::CH_9, 0);
			send(pse_pkg::CH_0 + 8'd3, 0);
			send(OPS[k], 1);
		end
		send(pse_pkg::CH_0 + 8'd7, 0);
		send(pse_pkg::CH_0, 0);
		send(pse_pkg::CH_DIV, 1);          // divide by zero
		send(pse_pkg::CH_0 + 8'd7, 0);
		send(pse_pkg::CH_0, 0);
		send(pse_pkg::CH_REM, 1);          // remainder by zero
		send(pse_pkg::CH_ADD, 1);          // underflow
		send(8'hFF, 1);                    // unknown operator on empty stack
		send(8'h00, 1);
		// a product of multiplies divided by -1, with -1 built via 0-1
		send(pse_pkg::CH_0, 0); send(pse_pkg::CH_0 + 8'd1, 0); send(pse_pkg::CH_SUB, 0);
		send(pse_pkg::CH_0 + 8'd8, 0);
		for (int i = 0; i < 10; i++) begin
			send(pse_pkg::CH_0 + 8'd8, 0); send(pse_pkg::CH_MUL, 0);
		end
		send(pse_pkg::CH_0 + 8'd2, 0); send(pse_pkg::CH_MUL, 0);   // 2^34, wraps to 0
		send(pse_pkg::CH_0, 0); send(pse_pkg::CH_0 + 8'd1, 0); send(pse_pkg::CH_SUB, 0);
		send(pse_pkg::CH_DIV, 1);
		// overflow: 17 digits
		for (int i = 0; i < 17; i++)
			send(digit(), i == 16);

		// receiver holds off while the sender keeps going
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++)
				send(digit(), 1);
		join

		count = 0;
		while (count < 860) begin
			calm = (count > 400 && count < 550);
			if ($urandom_range(99) < 80) begin
				int n;
				n = $urandom_range(1, 9);
				expression(n);
				count += 2 * n - 1;
			end else begin
				int n;
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					case ($urandom_range(2))
						0: send(digit(), i == n - 1);
						1: send(any_op(), i == n - 1);
						default: send(pse_pkg::TOK_W'($urandom),
							i == n - 1 || $urandom_range(1));
					endcase
				count += n;
			end
		end
		send(pse_pkg::TOK_W'($urandom), 1);
		@(negedge clk);
		push <= 0;
		calm = 1;

		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
